FILE: rtl/aus_pkg.sv
// shared types and constants for the annex b access unit splitter
package aus_pkg;

  localparam int RES_W  = 32;
  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [31:0] START_CODE = 32'h0000_0001;
  localparam logic [7:0]  TYPE_MASK  = 8'h1f;

  localparam logic [4:0] NAL_NON_IDR = 5'h01;
  localparam logic [4:0] NAL_IDR     = 5'h05;
  localparam logic [4:0] NAL_SEI     = 5'h06;
  localparam logic [4:0] NAL_SPS     = 5'h07;
  localparam logic [4:0] NAL_AUD     = 5'h09;

  // one result item
  typedef struct packed {
    logic             final_frame;
    logic [RES_W-1:0] frame_length;
    logic [RES_W-1:0] frame_start;
  } res_t;

  // results of one processed byte, packed from slot 0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_wr_t;

  // result queue status
  typedef struct packed {
    logic           room;
    logic [QCW-1:0] count;
  } q_stat_t;

endpackage

FILE: rtl/annexb_access_unit_splitter_top.sv
// top level of the annex b access unit splitter
//
// scans an h.264 annex b byte stream, one byte per item on the s_ side, and
// reports one item per access unit on the m_ side: the byte position of the
// frame's first start code and its length up to the next frame boundary or
// the end of the stream. a byte is taken every clock when the output side
// keeps up; it is captured in the input register, processed against the
// scan state once the queue has room, and its results are registered in a
// four-entry result queue that feeds the m_ side. one byte can close a
// frame and end the stream at once and then yields two results; the queue
// drains one per cycle while m_tready is high, and input stalls only while
// it has under two free entries. positions saturate at 2^OFFSET_BITS - 1;
// the byte flagged by s_tlast returns the scan state to its reset value.
module annexb_access_unit_splitter_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] frame_start, [63:32] frame_length
  output logic        m_tlast    // final_frame
);
  import aus_pkg::*;

  logic    fire;
  res_wr_t wr;
  res_t    out_res;
  q_stat_t stat;

  // byte register, start code detect and frame boundary decision
  aus_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .room     (stat.room),
    .fire     (fire),
    .wr       (wr)
  );

  // results wait here until the m_ side takes them
  aus_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .stat      (stat)
  );

  assign m_tdata = {out_res.frame_length, out_res.frame_start};
  assign m_tlast = out_res.final_frame;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  // second result slot only used when the first is
  a_wr_packed: assert property (@(posedge clk) disable iff (rst)
    wr.v1 |-> wr.v0)
    else $error("result write not packed");

  // a final frame is always the last result of its byte
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    wr.v1 |-> (!wr.r0.final_frame && wr.r1.final_frame))
    else $error("final frame not last of its byte");

  // results only come from a processed byte
  a_wr_fire: assert property (@(posedge clk) disable iff (rst)
    wr.v0 |-> fire)
    else $error("result written without a processed byte");

endmodule

FILE: rtl/aus_core.sv
// input register, start code scan and frame boundary state
module aus_core #(
  parameter int OFFSET_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             room,
  output logic             fire,
  output aus_pkg::res_wr_t wr
);
  import aus_pkg::*;

  localparam int W = OFFSET_BITS;
  localparam logic [W-1:0] POS_MAX = {W{1'b1}};
  localparam logic [W-1:0] FOUR    = W'(4);

  // input register
  logic       held;
  logic [7:0] hbyte;
  logic       hlast;

  // stream state
  logic [W-1:0] pos, pos_next;
  logic [31:0]  recent, recent_next;
  logic [W-1:0] pstart, pstart_next;
  logic         svalid, svalid_next;
  logic         sfound, sfound_next;

  logic [4:0]   nal_type;
  logic         start_hit, opener, is_non;
  logic [W-1:0] here, pos_inc;
  logic         close_v, fin_v;
  logic [W-1:0] close_len, fin_len;
  logic [W+RES_W-1:0] ext_cs, ext_cl, ext_fs, ext_fl;

  assign fire     = held && room;
  assign in_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      hbyte <= in_byte;
      hlast <= in_last;
    end
  end

  always_comb begin
    nal_type  = hbyte[4:0] & TYPE_MASK[4:0];
    start_hit = (recent == START_CODE);
    opener    = (nal_type == NAL_SPS) || (nal_type == NAL_SEI) || (nal_type == NAL_AUD);
    is_non    = (nal_type == NAL_NON_IDR);
    here      = (pos >= FOUR) ? pos - FOUR : '0;
    pos_inc   = (pos == POS_MAX) ? pos : pos + W'(1);

    pstart_next = pstart;
    svalid_next = svalid;
    sfound_next = sfound;
    close_v     = 1'b0;

    if (start_hit) begin
      if (opener || is_non) begin
        if (sfound) begin
          close_v     = (here > pstart);
          pstart_next = here;
          svalid_next = 1'b1;
          sfound_next = is_non;
        end else if (is_non) begin
          pstart_next = here;
          svalid_next = 1'b1;
          sfound_next = 1'b1;
        end else if (!svalid) begin
          pstart_next = here;
          svalid_next = 1'b1;
        end
      end else if (nal_type == NAL_IDR) begin
        if (svalid) begin
          sfound_next = 1'b1;
        end
      end
    end

    close_len = here - pstart;
    fin_v     = hlast && svalid_next && sfound_next && (pos_inc > pstart_next);
    fin_len   = pos_inc - pstart_next;

    // zero-extend or truncate offsets to the result width
    ext_cs = {{RES_W{1'b0}}, pstart};
    ext_cl = {{RES_W{1'b0}}, close_len};
    ext_fs = {{RES_W{1'b0}}, pstart_next};
    ext_fl = {{RES_W{1'b0}}, fin_len};

    recent_next = {recent[23:0], hbyte};
    pos_next    = pos_inc;
    if (hlast) begin
      pos_next    = '0;
      recent_next = '1;
      pstart_next = '0;
      svalid_next = 1'b0;
      sfound_next = 1'b0;
    end

    wr = '0;
    if (fire) begin
      if (close_v) begin
        wr.v0                 = 1'b1;
        wr.r0.frame_start     = ext_cs[RES_W-1:0];
        wr.r0.frame_length    = ext_cl[RES_W-1:0];
        wr.r0.final_frame     = 1'b0;
        wr.v1                 = fin_v;
        wr.r1.frame_start     = ext_fs[RES_W-1:0];
        wr.r1.frame_length    = ext_fl[RES_W-1:0];
        wr.r1.final_frame     = 1'b1;
      end else begin
        wr.v0                 = fin_v;
        wr.r0.frame_start     = ext_fs[RES_W-1:0];
        wr.r0.frame_length    = ext_fl[RES_W-1:0];
        wr.r0.final_frame     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      recent <= '1;
      pstart <= '0;
      svalid <= 1'b0;
      sfound <= 1'b0;
    end else if (fire) begin
      pos    <= pos_next;
      recent <= recent_next;
      pstart <= pstart_next;
      svalid <= svalid_next;
      sfound <= sfound_next;
    end
  end

endmodule

FILE: rtl/aus_res_queue.sv
// shifting result queue, up to two writes and one read per cycle
module aus_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  aus_pkg::res_wr_t wr,
  output logic             out_valid,
  input  logic             out_ready,
  output aus_pkg::res_t    out_res,
  output aus_pkg::q_stat_t stat
);
  import aus_pkg::*;

  res_t           q [QDEPTH];
  res_t           q_next [QDEPTH];
  logic [QCW-1:0] count, count_next, base, base1;
  logic           pop;

  assign out_valid = (count != '0);
  assign out_res   = q[0];
  assign pop       = out_valid && out_ready;

  always_comb begin
    base       = count - QCW'(pop);
    base1      = base + QCW'(1);
    count_next = base + QCW'(wr.v0) + QCW'(wr.v1);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_next[i] = q[(i + 1) % QDEPTH];
      end else begin
        q_next[i] = q[i];
      end
      if (wr.v0 && (QCW'(i) == base)) begin
        q_next[i] = wr.r0;
      end
      if (wr.v1 && (QCW'(i) == base1)) begin
        q_next[i] = wr.r1;
      end
    end
    stat.count = count;
    stat.room  = (base <= QCW'(QDEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the annex b access unit splitter: byte streams in, frame items checked
module testbench;
  import aus_pkg::*;

  localparam int OFFSET_BITS  = 32;
  localparam logic [63:0] POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int RANDOM_ITEMS = 1050;
  localparam int TAIL_ITEMS   = 150;   // no idling once this few bytes are left
  localparam int HOLD_AFTER   = 300;   // bytes taken before the long output hold
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 20;

  // one input item waiting to be sent
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  annexb_access_unit_splitter_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes still to send, and frames the scanner model says must come out
  stream_item_t byte_q[$];
  res_t         frames_expected[$];

  // scanner model state, same reset values as the block
  logic [63:0] scan_pos       = '0;
  logic [31:0] scan_window    = '1;
  logic [63:0] open_start     = '0;
  logic        open_valid     = 1'b0;
  logic        open_has_slice = 1'b0;

  // handshake bookkeeping shared by the driver, receiver and monitor
  logic in_taken    = 1'b0;
  int   bytes_taken = 0;
  int   mismatches  = 0;
  int   idle_cycles = 0;
  int   send_gap    = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  logic long_hold   = 1'b0;

  // positions stop at the top of the offset range
  function automatic logic [63:0] pos_inc(input logic [63:0] p);
    return (p >= POS_MAX) ? POS_MAX : p + 64'd1;
  endfunction

  // a frame of zero length is dropped, the boundary still counts
  task automatic push_frame(input logic [63:0] from, input logic [63:0] upto,
                            input logic fin);
    if (upto > from)
      frames_expected.push_back('{final_frame: fin, frame_length: 32'(upto - from),
                                  frame_start: 32'(from)});
  endtask

  // advance the scanner model by one byte and queue the frames it closes
  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [63:0] here;
    logic [4:0]  nal;
    logic        opener;
    if (scan_window == START_CODE) begin
      // the start code began four bytes back
      here   = (scan_pos >= 64'd4) ? scan_pos - 64'd4 : 64'd0;
      nal    = 5'(b & TYPE_MASK);
      opener = (nal == NAL_SPS) || (nal == NAL_SEI) || (nal == NAL_AUD);
      if (opener || nal == NAL_NON_IDR) begin
        if (open_has_slice) begin
          // close the current frame, this start code opens the next one
          push_frame(open_start, here, 1'b0);
          open_start     = here;
          open_valid     = 1'b1;
          open_has_slice = (nal == NAL_NON_IDR);
        end else if (nal == NAL_NON_IDR) begin
          // slice with no slice before it: frame restarts here
          open_start     = here;
          open_valid     = 1'b1;
          open_has_slice = 1'b1;
        end else if (!open_valid) begin
          open_start = here;
          open_valid = 1'b1;
        end
      end else if (nal == NAL_IDR) begin
        // idr only counts inside an opened frame
        if (open_valid)
          open_has_slice = 1'b1;
      end
    end
    scan_window = {scan_window[23:0], b};
    if (last) begin
      // end of stream: flush a frame holding a slice, then back to reset
      if (open_valid && open_has_slice)
        push_frame(open_start, pos_inc(scan_pos), 1'b1);
      scan_pos       = '0;
      scan_window    = '1;
      open_start     = '0;
      open_valid     = 1'b0;
      open_has_slice = 1'b0;
    end else begin
      scan_pos = pos_inc(scan_pos);
    end
  endtask

  // queue one stream, flagging its final byte
  task automatic put_stream(ref logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++)
      byte_q.push_back('{last: (i == s.size() - 1), data: s[i]});
  endtask

  // four-byte start code followed by the nal header byte
  task automatic put_code(ref logic [7:0] s[$], input logic [7:0] hdr);
    s.push_back(8'h00);
    s.push_back(8'h00);
    s.push_back(8'h00);
    s.push_back(8'h01);
    s.push_back(hdr);
  endtask

  // mostly the types that steer the splitter, sometimes any other type
  function automatic logic [4:0] pick_nal();
    int pick;
    pick = $urandom_range(0, 9);
    unique case (pick)
      0, 1:    return NAL_NON_IDR;
      2, 3:    return NAL_IDR;
      4:       return NAL_SEI;
      5:       return NAL_SPS;
      6:       return NAL_AUD;
      default: return 5'($urandom);
    endcase
  endfunction

  // one nal unit with random content, a broken start code, or plain noise
  task automatic add_unit(ref logic [7:0] s[$]);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 92) begin
      if (pick < 82) begin
        put_code(s, {3'($urandom), pick_nal()});
      end else begin
        // three-byte start code, only counts if a zero came just before
        s.push_back(8'h00);
        s.push_back(8'h00);
        s.push_back(8'h01);
        s.push_back({3'($urandom), pick_nal()});
      end
      n = $urandom_range(0, 6);
      repeat (n) s.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom));
    end
  endtask

  // sender: holds each item until taken, idles in bursts
  always @(negedge clk) begin : driver
    stream_item_t nxt;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
          // keep offering during the long hold so the block backs up
          if (byte_q.size() >= TAIL_ITEMS && !long_hold && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
        if (hold_left == 0)
          long_hold = 1'b0;
      end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        long_hold = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (byte_q.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 10);
      end
    end
  end

  // monitor: model accepted bytes, check accepted frames, watch for a hang
  always @(posedge clk) begin : monitor
    res_t        want;
    logic [31:0] got_start;
    logic [31:0] got_len;
    logic        in_fire;
    logic        out_fire;
    in_fire  = s_tvalid && s_tready;
    out_fire = m_tvalid && m_tready;
    if (!rst) begin
      if (in_fire) begin
        scan_byte(s_tdata, s_tlast);
        in_taken = 1'b1;
        bytes_taken++;
      end
      if (out_fire) begin
        got_start = m_tdata[31:0];
        got_len   = m_tdata[63:32];
        if (frames_expected.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected frame: start %0d length %0d final %0b",
                     got_start, got_len, m_tlast);
          mismatches++;
        end else begin
          want = frames_expected.pop_front();
          if (got_start !== want.frame_start || got_len !== want.frame_length ||
              m_tlast !== want.final_frame) begin
            if (mismatches < 10)
              $display({"frame mismatch: expected start %0d length %0d final %0b,",
                        " got start %0d length %0d final %0b"},
                       want.frame_start, want.frame_length, want.final_frame,
                       got_start, got_len, m_tlast);
            mismatches++;
          end
        end
      end
      if (in_fire || out_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] s[$];
    int         target;
    int         units;

    // short stream, one byte, no frame
    s.push_back(8'hff);
    put_stream(s);

    // aud opens, sps inside an open frame does nothing, idr marks a slice,
    // then a non-idr slice header with high bits set closes the frame on the
    // last byte and is flushed at once as a final frame of length five
    s.delete();
    put_code(s, 8'h09);
    put_code(s, 8'hc7);
    put_code(s, 8'h65);
    s.push_back(8'hff);
    put_code(s, 8'he1);
    put_stream(s);

    // random streams: mostly well-formed units, some broken codes and noise
    target = byte_q.size() + RANDOM_ITEMS;
    while (byte_q.size() < target) begin
      s.delete();
      if ($urandom_range(0, 99) < 7) begin
        // too short to carry a start code and a header
        repeat ($urandom_range(1, 4)) s.push_back(8'($urandom));
      end else begin
        units = $urandom_range(1, 8);
        repeat (units) add_unit(s);
      end
      put_stream(s);
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (byte_q.size() != 0 || s_tvalid) @(posedge clk);
    while (frames_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/aus_pkg.sv
rtl/aus_core.sv
rtl/aus_res_queue.sv
rtl/annexb_access_unit_splitter_top.sv
bench/testbench.sv
